### rtl/core/dlr_pkg.sv
// Package for the DDA line rasteriser: opcodes and the command and status
// structures passed between the controller and the datapath. No dependencies.
package dlr_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic capture;
        logic setup;
        logic div_step;
        logic div_last;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic major_zero;
    } t_dp_status;

endpackage

### rtl/core/dlr_controller.sv
// Sequencer of the DDA line rasteriser: accepts requests and drives the
// capture, setup, slope division and step commands of the datapath. Depends on dlr_pkg.
module dlr_controller
    import dlr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_opcode,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SETUP = 3'b010,
        S_DIV   = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            accept;
    logic            cnt_last;

    assign o_in_ready = (r_state == S_IDLE) && i_status.out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign cnt_last   = (r_cnt == CW'(FRAC_BITS));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_START) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_SETUP;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_cnt       = '0;
                n_state     = i_status.major_zero ? S_IDLE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_last = cnt_last;
                n_cnt          = r_cnt + CW'(1);
                if (cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### rtl/core/dlr_datapath.sv
// Datapath of the DDA line rasteriser: endpoint ordering, restoring slope
// division, the minor accumulator and the output register. Depends on dlr_pkg.
module dlr_datapath
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_pixel_valid,
    output logic                         o_last_pixel
);

    localparam int CB = COORD_BITS;
    localparam int FB = FRAC_BITS;
    localparam int AW = CB + FB + 1;
    localparam logic [AW:0] HALF = (AW + 1)'(1) << (FB - 1);

    logic signed [CB-1:0] r_sx, r_sy, r_ex, r_ey;
    logic                 r_y_major;
    logic signed [CB-1:0] r_pos, r_end;
    logic signed [AW-1:0] r_acc, r_inc;
    logic                 r_active;
    logic [CB:0]          r_dmaj;
    logic [CB+1:0]        r_rem;
    logic [FB:0]          r_quo;
    logic                 r_neg;
    logic                 r_out_valid;
    logic signed [CB-1:0] r_px, r_py;
    logic                 r_pv, r_pl;

    logic signed [CB:0]   dx, dy;
    logic [CB:0]          adx, ady;
    logic signed [CB-1:0] ma0_raw, ma1_raw, mi0_raw, mi1_raw;
    logic signed [CB-1:0] ma0, ma1, mi0, mi1;
    logic                 swap;
    logic signed [CB:0]   dmaj, dmin;
    logic [CB:0]          dmin_abs;
    logic [CB+1:0]        dmaj_ext, diff;
    logic                 ge;
    logic [FB:0]          quo_n;
    logic [AW-1:0]        q_ext;
    logic signed [CB-1:0] pos_n;
    logic signed [AW-1:0] acc_n;
    logic [AW:0]          rnd;
    logic [CB-1:0]        minor_n;

    assign dx  = {i_end_x[CB-1], i_end_x} - {i_start_x[CB-1], i_start_x};
    assign dy  = {i_end_y[CB-1], i_end_y} - {i_start_y[CB-1], i_start_y};
    assign adx = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
    assign ady = dy[CB] ? $unsigned(-dy) : $unsigned(dy);

    assign ma0_raw = r_y_major ? r_sy : r_sx;
    assign ma1_raw = r_y_major ? r_ey : r_ex;
    assign mi0_raw = r_y_major ? r_sx : r_sy;
    assign mi1_raw = r_y_major ? r_ex : r_ey;
    assign swap    = ma0_raw > ma1_raw;
    assign ma0     = swap ? ma1_raw : ma0_raw;
    assign ma1     = swap ? ma0_raw : ma1_raw;
    assign mi0     = swap ? mi1_raw : mi0_raw;
    assign mi1     = swap ? mi0_raw : mi1_raw;
    assign dmaj    = {ma1[CB-1], ma1} - {ma0[CB-1], ma0};
    assign dmin    = {mi1[CB-1], mi1} - {mi0[CB-1], mi0};
    assign dmin_abs = dmin[CB] ? $unsigned(-dmin) : $unsigned(dmin);

    assign dmaj_ext = {1'b0, r_dmaj};
    assign ge       = r_rem >= dmaj_ext;
    assign diff     = ge ? r_rem - dmaj_ext : r_rem;
    assign quo_n    = {r_quo[FB-1:0], ge};
    assign q_ext    = {{(AW-FB-1){1'b0}}, quo_n};

    assign pos_n   = r_pos + CB'(1);
    assign acc_n   = r_acc + r_inc;
    assign rnd     = {acc_n[AW-1], acc_n} + HALF;
    assign minor_n = rnd[FB+CB-1:FB];

    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.major_zero = (dmaj == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sx      <= i_start_x;
            r_sy      <= i_start_y;
            r_ex      <= i_end_x;
            r_ey      <= i_end_y;
            r_y_major <= ady > adx;
        end
        if (i_cmd.setup) begin
            r_pos  <= ma0;
            r_end  <= ma1;
            r_acc  <= {mi0[CB-1], mi0, {FB{1'b0}}};
            r_inc  <= '0;
            r_dmaj <= dmaj;
            r_rem  <= {1'b0, dmin_abs};
            r_neg  <= dmin[CB];
            r_quo  <= '0;
            r_px   <= r_y_major ? mi0 : ma0;
            r_py   <= r_y_major ? ma0 : mi0;
            r_pv   <= 1'b1;
            r_pl   <= (ma0 == ma1);
        end
        if (i_cmd.div_step) begin
            r_rem <= {diff[CB:0], 1'b0};
            r_quo <= quo_n;
            if (i_cmd.div_last) begin
                r_inc <= r_neg ? $signed(-q_ext) : $signed(q_ext);
            end
        end
        if (i_cmd.step) begin
            if (r_active) begin
                r_pos <= pos_n;
                r_acc <= acc_n;
                r_px  <= r_y_major ? minor_n : pos_n;
                r_py  <= r_y_major ? pos_n : minor_n;
                r_pv  <= 1'b1;
                r_pl  <= !(pos_n < r_end);
            end else begin
                r_px <= '0;
                r_py <= '0;
                r_pv <= 1'b0;
                r_pl <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.setup) begin
                r_active <= (ma0 != ma1);
            end else if (i_cmd.step && r_active) begin
                r_active <= pos_n < r_end;
            end
            if (i_cmd.setup || i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_valid = r_pv;
    assign o_last_pixel  = r_pl;

endmodule

### rtl/core/dda_line_rasterizer_unit.sv
// Top level of the DDA line rasteriser: joins the controller and the datapath.
// Depends on dlr_pkg, dlr_controller and dlr_datapath.
//
// Usage: requests arrive on the s_axis channel. tuser carries the opcode
// (start a line or step to the next pixel) and tdata the two endpoints, used
// only by a start. Every request gives exactly one result on m_axis: tdata
// holds the pixel, tuser says whether a pixel is given and tlast marks the
// final pixel of the line. A step with no line in progress returns an
// invalid result with all fields zero.
// Throughput: a step is accepted and its result is in the output register
// on the next cycle, so steps run at one per cycle while m_axis takes each
// result. A start is captured, then the endpoints are ordered and the first
// pixel is emitted, then the one-bit-per-cycle restoring slope divider runs;
// tready stays low after the capture until the division ends. A line
// whose endpoints coincide skips the division.
// Reset: synchronous and active low; no line is active and the output
// register is empty afterwards.
// Back-pressure: while a result waits on m_axis, tready stays low unless the
// result is taken in the same cycle; results are held stable until taken.
module dda_line_rasterizer_unit
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Fields from bit 0: start_x, start_y, end_x, end_y, zero padding.
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic                                    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // Fields from bit 0: pixel_x, pixel_y, zero padding.
    output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
    // Fields from bit 0: pixel_valid.
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast
);

    localparam int CB    = COORD_BITS;
    localparam int OUT_W = ((2*CB+7)/8)*8;

    t_dp_cmd              cmd;
    t_dp_status           status;
    logic signed [CB-1:0] pixel_x, pixel_y;

    dlr_controller #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dlr_datapath #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_start_x     (s_axis_tdata[CB-1:0]),
        .i_start_y     (s_axis_tdata[2*CB-1:CB]),
        .i_end_x       (s_axis_tdata[3*CB-1:2*CB]),
        .i_end_y       (s_axis_tdata[4*CB-1:3*CB]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_pixel_valid (m_axis_tuser),
        .o_last_pixel  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

### rtl/core/dlr_checker.sv
// Port-level checks for the DDA line rasteriser, bound to the top level.
// Depends on dda_line_rasterizer_unit and dlr_pkg.
module dlr_checker
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              m_axis_tlast
);

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    a_last_needs_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("last pixel flagged on an invalid result");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0) && !m_axis_tlast)
        else $error("invalid result carries non-zero fields");

    a_start_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (s_axis_tuser == OP_START) |=> !s_axis_tready)
        else $error("request taken during line setup");

    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (s_axis_tuser == OP_STEP) |=> m_axis_tvalid)
        else $error("step request gave no result on the next cycle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind dda_line_rasterizer_unit dlr_checker #(.COORD_BITS(COORD_BITS)) u_dlr_checker (.*);

### tb/sv/dda_line_rasterizer_unit_tb.sv
// Self-checking testbench for dda_line_rasterizer_unit: directed rows, then random line and raw requests.
// Each result is checked against a predictor of the line walk built in here, or against the value in its row.
// Depends on dlr_pkg and the top level of the rasteriser.
module dda_line_rasterizer_unit_tb;
    import dlr_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int IN_BITS    = ((4*COORD_BITS+7)/8)*8;
    localparam int OUT_BITS   = ((2*COORD_BITS+7)/8)*8;
    localparam int RANDOM_ITEMS = 1650;

    typedef logic signed [COORD_BITS-1:0]           coord_t;
    typedef logic signed [COORD_BITS+FRAC_BITS:0]   fixed_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        logic   valid;
        logic   is_last;
    } pixel_t;

    typedef struct {
        logic   op;
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        bit     known;
        pixel_t want;
    } row_t;

    typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;

    coord_t   walk_pos;
    coord_t   walk_end;
    fixed_t   minor_acc;
    fixed_t   minor_inc;
    logic     walk_y_major;
    logic     walk_active;

    pixel_t   pending_pixels[$];
    row_t     directed_rows[$];
    int       fail_count;
    int       items_sent;
    int       burst_left;
    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_phase;

    dda_line_rasterizer_unit #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic pixel_t shade_pixel(input logic is_last);
        longint minor;
        pixel_t p;
        minor = (longint'(minor_acc) + (longint'(1) << (FRAC_BITS-1))) >>> FRAC_BITS;
        p.px      = walk_y_major ? coord_t'(minor) : walk_pos;
        p.py      = walk_y_major ? walk_pos : coord_t'(minor);
        p.valid   = 1'b1;
        p.is_last = is_last;
        return p;
    endfunction

    function automatic pixel_t next_pixel(input logic op, input coord_t x0, input coord_t y0,
                                          input coord_t x1, input coord_t y1);
        longint ax0, ay0, ax1, ay1, adx, ady;
        longint ma0, ma1, mi0, mi1, swap, dmaj, dmin, mag, quot;
        pixel_t p;
        p = '0;
        if (op == OP_START) begin
            ax0 = x0;
            ay0 = y0;
            ax1 = x1;
            ay1 = y1;
            adx = (ax1 > ax0) ? ax1 - ax0 : ax0 - ax1;
            ady = (ay1 > ay0) ? ay1 - ay0 : ay0 - ay1;
            walk_y_major = ady > adx;
            if (walk_y_major) begin
                ma0 = ay0; ma1 = ay1; mi0 = ax0; mi1 = ax1;
            end else begin
                ma0 = ax0; ma1 = ax1; mi0 = ay0; mi1 = ay1;
            end
            if (ma0 > ma1) begin
                swap = ma0; ma0 = ma1; ma1 = swap;
                swap = mi0; mi0 = mi1; mi1 = swap;
            end
            dmaj = ma1 - ma0;
            dmin = mi1 - mi0;
            if (dmaj == 0) begin
                minor_inc = '0;
            end else begin
                mag  = ((dmin < 0) ? -dmin : dmin) << FRAC_BITS;
                quot = mag / dmaj;
                minor_inc = fixed_t'((dmin < 0) ? -quot : quot);
            end
            walk_pos    = coord_t'(ma0);
            walk_end    = coord_t'(ma1);
            minor_acc   = fixed_t'(mi0 * (longint'(1) << FRAC_BITS));
            walk_active = walk_pos != walk_end;
            p = shade_pixel(!walk_active);
        end else if (walk_active) begin
            walk_pos    = walk_pos + coord_t'(1);
            minor_acc   = minor_acc + minor_inc;
            walk_active = walk_pos < walk_end;
            p = shade_pixel(!walk_active);
        end
        return p;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > 2047) return 2047;
        if (v < -2048) return -2048;
        return v;
    endfunction

    function automatic logic [IN_BITS-1:0] random_payload();
        logic [IN_BITS-1:0] w;
        w = '0;
        w[31:0] = $urandom;
        w[IN_BITS-1:32] = (IN_BITS-32)'($urandom);
        return w;
    endfunction

    task automatic add_row(input logic op, input int x0, input int y0, input int x1,
                           input int y1, input bit known, input int ex, input int ey,
                           input logic ev, input logic el);
        row_t r;
        r.op    = op;
        r.x0    = coord_t'(x0);
        r.y0    = coord_t'(y0);
        r.x1    = coord_t'(x1);
        r.y1    = coord_t'(y1);
        r.known = known;
        r.want  = '{px: coord_t'(ex), py: coord_t'(ey), valid: ev, is_last: el};
        directed_rows.push_back(r);
    endtask

    task automatic send_request(input logic op, input logic [IN_BITS-1:0] data,
                                input bit known, input pixel_t typed);
        int     gap;
        pixel_t want;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = next_pixel(op, data[COORD_BITS-1:0], data[2*COORD_BITS-1:COORD_BITS],
                          data[3*COORD_BITS-1:2*COORD_BITS], data[4*COORD_BITS-1:3*COORD_BITS]);
        if (known) want = typed;
        pending_pixels.push_back(want);
        items_sent++;
        burst_left--;
    endtask

    task automatic run_line_sequence();
        int kind, reach, x0, y0, x1, y1, span, n_steps;
        logic [IN_BITS-1:0] data;
        kind = $urandom_range(0, 99);
        if (kind >= 94) begin
            repeat ($urandom_range(1, 6)) send_request(1'($urandom), random_payload(), 0, '0);
            return;
        end
        reach = (kind < 70) ? 15 : ((kind < 86) ? 200 : 0);
        x0 = int'($urandom_range(0, 4095)) - 2048;
        y0 = int'($urandom_range(0, 4095)) - 2048;
        if (reach == 0) begin
            x1 = int'($urandom_range(0, 4095)) - 2048;
            y1 = int'($urandom_range(0, 4095)) - 2048;
        end else if ($urandom_range(0, 19) == 0) begin
            x1 = x0;
            y1 = y0;
        end else begin
            x1 = clamp_coord(x0 + int'($urandom_range(0, 2*reach)) - reach);
            y1 = clamp_coord(y0 + int'($urandom_range(0, 2*reach)) - reach);
        end
        span = (x1 > x0) ? x1 - x0 : x0 - x1;
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > span) span = (y1 > y0) ? y1 - y0 : y0 - y1;
        data = random_payload();
        data[4*COORD_BITS-1:0] = {12'(y1), 12'(x1), 12'(y0), 12'(x0)};
        send_request(OP_START, data, 0, '0);
        if (reach == 0) n_steps = $urandom_range(0, 40);
        else if ($urandom_range(0, 9) < 8) n_steps = span + $urandom_range(0, 2);
        else n_steps = $urandom_range(0, span);
        repeat (n_steps) send_request(OP_STEP, random_payload(), 0, '0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_mode       <= RX_OPEN;
            rx_left       <= 0;
            rx_phase      <= 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(32, 256);
            end else begin
                rx_left <= rx_left - 1;
            end
            rx_phase <= (rx_phase == 6) ? 0 : rx_phase + 1;
            case (rx_mode)
                RX_OPEN:     m_axis_tready <= 1'b1;
                RX_BUSY:     m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_axis_tready <= (rx_phase < 4);
                default:     m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        pixel_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result: pixel_x %0d, pixel_y %0d, pixel_valid %0d",
                       $signed(m_axis_tdata[COORD_BITS-1:0]),
                       $signed(m_axis_tdata[2*COORD_BITS-1:COORD_BITS]), m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                compare_field("pixel_x", int'(want.px), $signed(m_axis_tdata[COORD_BITS-1:0]));
                compare_field("pixel_y", int'(want.py),
                              $signed(m_axis_tdata[2*COORD_BITS-1:COORD_BITS]));
                compare_field("pixel_valid", int'(want.valid), int'(m_axis_tuser));
                compare_field("last_pixel", int'(want.is_last), int'(m_axis_tlast));
            end
        end
    end

    initial begin
        logic [IN_BITS-1:0] data;
        row_t               r;
        fail_count   = 0;
        items_sent   = 0;
        burst_left   = 0;
        walk_pos     = '0;
        walk_end     = '0;
        minor_acc    = '0;
        minor_inc    = '0;
        walk_y_major = 1'b0;
        walk_active  = 1'b0;

        // A step straight after reset, and single-pixel lines, have obvious results.
        add_row(OP_STEP,      0,     0,     0,     0, 1,     0,     0, 1'b0, 1'b0);
        add_row(OP_START,     0,     0,     0,     0, 1,     0,     0, 1'b1, 1'b1);
        add_row(OP_STEP,      0,     0,     0,     0, 1,     0,     0, 1'b0, 1'b0);
        add_row(OP_START,  2047,  2047,  2047,  2047, 1,  2047,  2047, 1'b1, 1'b1);
        add_row(OP_START, -2048, -2048, -2048, -2048, 1, -2048, -2048, 1'b1, 1'b1);
        // The full diagonal is a tie, so x is the major axis.
        add_row(OP_START, -2048, -2048,  2047,  2047, 1, -2048, -2048, 1'b1, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_START,  2047, -2048, -2048,  2047, 1, -2048,  2047, 1'b1, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        // A horizontal line given backwards is swapped, then walked past its end.
        add_row(OP_START,     5,     3,     1,     3, 1,     1,     3, 1'b1, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 1,     0,     0, 1'b0, 1'b0);
        add_row(OP_START,     0,     0,     3,    -7, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        // A new start abandons the line in progress.
        add_row(OP_START,    10,    10,    13,    13, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_START,    -1,     0,     0,    -1, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);
        add_row(OP_STEP,      0,     0,     0,     0, 0,     0,     0, 1'b0, 1'b0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            data = '0;
            data[4*COORD_BITS-1:0] = {r.y1, r.x1, r.y0, r.x0};
            send_request(r.op, data, r.known, r.want);
        end

        while (items_sent < RANDOM_ITEMS + directed_rows.size()) run_line_sequence();
        s_axis_tvalid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (FRAC_BITS + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
